FILE: hw/rtl/bsfd_pkg.sv
// Shared types, constants and the CRC-16/X.25 byte update for the byte-stuffed frame decoder.
package bsfd_pkg;

  localparam logic [7:0]  MARK_START = 8'h7B;
  localparam logic [7:0]  MARK_ESC   = 8'h5C;
  localparam logic [7:0]  MARK_END   = 8'h7D;
  localparam logic [7:0]  ESC_FLIP   = 8'h20;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_XOROUT = 16'hFFFF;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd256;

  localparam logic [1:0]  KIND_DATA = 2'd0;
  localparam logic [1:0]  KIND_GOOD = 2'd1;
  localparam logic [1:0]  KIND_BAD  = 2'd2;
  localparam logic [1:0]  KIND_DROP = 2'd3;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic        CFG_IDX_MAX_PAYLOAD = 1'b0;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] count;
  } result_t;

  function automatic logic [15:0] crc_x25_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/bsfd_cfg_regs.sv
// APB-style configuration register block holding the largest accepted payload length.
module bsfd_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bsfd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready,
  output logic [15:0]                       max_payload
);

  logic [15:0] max_payload_r;
  logic        wr_en;
  logic        hit;

  assign cfg_pready = 1'b1;
  assign hit   = (cfg_paddr[bsfd_pkg::CFG_ADDR_W-1] == bsfd_pkg::CFG_IDX_MAX_PAYLOAD);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= bsfd_pkg::MAX_PAYLOAD_RESET;
    end else if (wr_en) begin
      max_payload_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata  = hit ? {16'h0000, max_payload_r} : 32'h0000_0000;
  assign max_payload = max_payload_r;

endmodule

FILE: hw/rtl/bsfd_in_reg.sv
// Input register stage that captures one received byte per transaction.
module bsfd_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 advance,
  output bsfd_pkg::in_item_t   item
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

  assign item.valid   = valid_r;
  assign item.rx_byte = byte_r;

endmodule

FILE: hw/rtl/bsfd_core.sv
// Deframing state machine, CRC check and result register.
module bsfd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  bsfd_pkg::in_item_t  item,
  input  logic [15:0]         max_payload,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          out_kind,
  output logic [7:0]          out_data_byte,
  output logic [15:0]         out_count
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_RECV = 2'd1;
  localparam logic [1:0] PH_ESCD = 2'd2;
  localparam logic [1:0] PH_SPARE = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  bsfd_pkg::result_t res_r;
  bsfd_pkg::result_t res;
  logic        res_valid;

  logic [7:0]  b;
  logic [7:0]  data_in;
  logic        take;
  logic        room;
  logic [16:0] limit;
  logic [16:0] cnt_less2;

  assign advance   = item.valid && (!out_valid_r || out_ready);
  assign b         = item.rx_byte;
  assign limit     = {1'b0, max_payload} + 17'd2;
  assign room      = (cnt_r < limit);
  assign cnt_less2 = cnt_r - 17'd2;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    tail_nxt  = tail_r;
    crc_nxt   = crc_r;
    res_valid = 1'b0;
    res       = '0;
    take      = 1'b0;
    data_in   = b;
    unique case (phase_r)
      PH_WAIT: begin
        if (b == bsfd_pkg::MARK_START) begin
          phase_nxt = PH_RECV;
          cnt_nxt   = '0;
          tail_nxt  = '0;
          crc_nxt   = bsfd_pkg::CRC_INIT;
        end
      end
      PH_RECV: begin
        priority if (b == bsfd_pkg::MARK_START) begin
          phase_nxt = PH_RECV;
          cnt_nxt   = '0;
          tail_nxt  = '0;
          crc_nxt   = bsfd_pkg::CRC_INIT;
          res_valid = 1'b1;
          res.kind  = bsfd_pkg::KIND_DROP;
        end else if (b == bsfd_pkg::MARK_ESC) begin
          phase_nxt = PH_ESCD;
        end else if (b == bsfd_pkg::MARK_END) begin
          phase_nxt = PH_WAIT;
          if (cnt_r >= 17'd2) begin
            res_valid = 1'b1;
            res.kind  = ((crc_r ^ bsfd_pkg::CRC_XOROUT) == tail_r) ?
                        bsfd_pkg::KIND_GOOD : bsfd_pkg::KIND_BAD;
            res.count = cnt_less2[15:0];
          end
        end else begin
          take = 1'b1;
        end
      end
      PH_ESCD: begin
        priority if (b == bsfd_pkg::MARK_START) begin
          phase_nxt = PH_RECV;
          cnt_nxt   = '0;
          tail_nxt  = '0;
          crc_nxt   = bsfd_pkg::CRC_INIT;
          res_valid = 1'b1;
          res.kind  = bsfd_pkg::KIND_DROP;
        end else if (b == bsfd_pkg::MARK_ESC || b == bsfd_pkg::MARK_END) begin
          phase_nxt = PH_WAIT;
          res_valid = 1'b1;
          res.kind  = bsfd_pkg::KIND_DROP;
        end else begin
          take    = 1'b1;
          data_in = b ^ bsfd_pkg::ESC_FLIP;
        end
      end
      PH_SPARE: begin
        phase_nxt = PH_WAIT;
      end
      default: begin
        phase_nxt = PH_WAIT;
      end
    endcase

    if (take) begin
      if (room) begin
        phase_nxt = PH_RECV;
        if (cnt_r >= 17'd2) begin
          res_valid      = 1'b1;
          res.kind       = bsfd_pkg::KIND_DATA;
          res.data_byte  = tail_r[7:0];
          res.count      = cnt_less2[15:0];
          crc_nxt        = bsfd_pkg::crc_x25_byte(crc_r, tail_r[7:0]);
        end
        tail_nxt = {data_in, tail_r[15:8]};
        cnt_nxt  = cnt_r + 17'd1;
      end else begin
        phase_nxt = PH_WAIT;
        res_valid = 1'b1;
        res       = '0;
        res.kind  = bsfd_pkg::KIND_DROP;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (advance) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      cnt_r       <= '0;
      tail_r      <= '0;
      crc_r       <= bsfd_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        tail_r  <= tail_nxt;
        crc_r   <= crc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = res_r.kind;
  assign out_data_byte = res_r.data_byte;
  assign out_count     = res_r.count;

endmodule

FILE: hw/rtl/byte_stuffed_frame_decoder_crc16_top.sv
// Top level of the byte-stuffed frame decoder with CRC-16/X.25 check.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   in_rx_byte[7:0]
//   out_     output     out_valid / out_ready out_kind[1:0], out_data_byte[7:0], out_count[15:0]
//   cfg_     config     APB write, pready=1   max_payload at byte address 0
//
// A byte is taken into the input register and its result, if any, is then written to the
// result register, so one transaction per cycle is sustained while out_ready is high.
// The rate is set by the frame state machine, which steps and updates its CRC a byte at a time.
// Reset is synchronous and active low; it clears the frame state and loads max_payload with 256.
// A stalled result holds the input register, and one further byte can wait in it meanwhile.
module byte_stuffed_frame_decoder_crc16_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_kind,
  output logic [7:0]                        out_data_byte,
  output logic [15:0]                       out_count,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bsfd_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  bsfd_pkg::in_item_t item;
  logic               advance;
  logic [15:0]        max_payload;

  bsfd_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_payload (max_payload)
  );

  bsfd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .advance    (advance),
    .item       (item)
  );

  bsfd_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .item          (item),
    .max_payload   (max_payload),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_count     (out_count)
  );

endmodule

FILE: hw/rtl/bsfd_checker.sv
// Port-level assertion checker for the frame decoder, bound to the top level.
module bsfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_data_byte,
  input logic [15:0] out_count,
  input logic        cfg_pready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data_byte)
                                && $stable(out_count))
    else $error("Result transaction changed while stalled.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input not ready although the result register is empty.");

  a_frame_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != bsfd_pkg::KIND_DATA |-> out_data_byte == 8'h00)
    else $error("Frame report carries a data byte.");

  a_drop_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == bsfd_pkg::KIND_DROP |-> out_count == 16'h0000)
    else $error("Dropped frame report carries a count.");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("Configuration port not ready.");

endmodule

bind byte_stuffed_frame_decoder_crc16_top bsfd_checker u_bsfd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_kind      (out_kind),
  .out_data_byte (out_data_byte),
  .out_count     (out_count),
  .cfg_pready    (cfg_pready)
);

FILE: tb/sv/byte_stuffed_frame_decoder_crc16_top_tb.sv
// Self-checking testbench for the byte-stuffed frame decoder with CRC-16/X.25 check.
`timescale 1ns / 1ps

module byte_stuffed_frame_decoder_crc16_top_tb;

  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 1700;
  localparam logic [bsfd_pkg::CFG_ADDR_W-1:0] MAX_PAYLOAD_ADDR =
    bsfd_pkg::CFG_ADDR_W'(4 * bsfd_pkg::CFG_IDX_MAX_PAYLOAD);

  typedef enum logic [1:0] {FR_HUNT, FR_BODY, FR_ESCAPED} frame_state_t;

  logic                            clk         = 1'b0;
  logic                            rst_n       = 1'b0;
  logic                            in_valid    = 1'b0;
  logic                            in_ready;
  logic [7:0]                      in_rx_byte  = 8'h00;
  logic                            out_valid;
  logic                            out_ready   = 1'b0;
  logic [1:0]                      out_kind;
  logic [7:0]                      out_data_byte;
  logic [15:0]                     out_count;
  logic                            cfg_psel    = 1'b0;
  logic                            cfg_penable = 1'b0;
  logic                            cfg_pwrite  = 1'b0;
  logic [bsfd_pkg::CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [31:0]                     cfg_pwdata  = '0;
  logic [31:0]                     cfg_prdata;
  logic                            cfg_pready;

  frame_state_t      fr_state      = FR_HUNT;
  logic [16:0]       stored_n      = '0;
  logic [15:0]       tail_pair     = '0;
  logic [15:0]       fcs_acc       = bsfd_pkg::CRC_INIT;
  logic [15:0]       payload_limit = bsfd_pkg::MAX_PAYLOAD_RESET;
  bsfd_pkg::result_t expected_q[$];
  logic [7:0]        body_buf[$];

  int unsigned errors        = 0;
  int unsigned decoded_bytes = 0;
  int unsigned payload_seen  = 0;
  int unsigned good_seen     = 0;
  int unsigned bad_seen      = 0;
  int unsigned drop_seen     = 0;
  int unsigned limit_writes  = 0;
  int unsigned cycle_count   = 0;
  bit          sender_calm   = 1'b0;
  bit          rx_calm       = 1'b0;
  int          stall_left    = 0;

  byte_stuffed_frame_decoder_crc16_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_kind      (out_kind),
    .out_data_byte (out_data_byte),
    .out_count     (out_count),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [15:0] x25_next(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      r = (r[0] ^ d[i]) ? ((r >> 1) ^ bsfd_pkg::CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic bit is_mark(input logic [7:0] d);
    return d == bsfd_pkg::MARK_START || d == bsfd_pkg::MARK_ESC || d == bsfd_pkg::MARK_END;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 6);
    end
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [7:0] line_byte(input int mark_pct);
    if ($urandom_range(0, 99) < mark_pct) begin
      case ($urandom_range(0, 2))
        0: return bsfd_pkg::MARK_START;
        1: return bsfd_pkg::MARK_ESC;
        default: return bsfd_pkg::MARK_END;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic expect_result(input logic [1:0] kind, input logic [7:0] data,
                               input logic [15:0] cnt);
    bsfd_pkg::result_t r;
    r.kind      = kind;
    r.data_byte = data;
    r.count     = cnt;
    expected_q.push_back(r);
  endtask

  task automatic open_frame_state();
    fr_state  = FR_BODY;
    stored_n  = '0;
    tail_pair = '0;
    fcs_acc   = bsfd_pkg::CRC_INIT;
  endtask

  task automatic store_unstuffed(input logic [7:0] b);
    if (stored_n < {1'b0, payload_limit} + 17'd2) begin
      fr_state = FR_BODY;
      if (stored_n >= 17'd2) begin
        expect_result(bsfd_pkg::KIND_DATA, tail_pair[7:0], stored_n[15:0] - 16'd2);
        fcs_acc = x25_next(fcs_acc, tail_pair[7:0]);
      end
      tail_pair = {b, tail_pair[15:8]};
      stored_n  = stored_n + 17'd1;
    end else begin
      fr_state = FR_HUNT;
      expect_result(bsfd_pkg::KIND_DROP, 8'h00, 16'h0000);
    end
  endtask

  task automatic decode_line_byte(input logic [7:0] b);
    if (fr_state != FR_HUNT || b == bsfd_pkg::MARK_START) begin
      decoded_bytes++;
    end
    case (fr_state)
      FR_HUNT: begin
        if (b == bsfd_pkg::MARK_START) begin
          open_frame_state();
        end
      end
      FR_BODY: begin
        if (b == bsfd_pkg::MARK_START) begin
          open_frame_state();
          expect_result(bsfd_pkg::KIND_DROP, 8'h00, 16'h0000);
        end else if (b == bsfd_pkg::MARK_ESC) begin
          fr_state = FR_ESCAPED;
        end else if (b == bsfd_pkg::MARK_END) begin
          fr_state = FR_HUNT;
          if (stored_n >= 17'd2) begin
            expect_result(((fcs_acc ^ bsfd_pkg::CRC_XOROUT) == tail_pair) ?
                          bsfd_pkg::KIND_GOOD : bsfd_pkg::KIND_BAD,
                          8'h00, stored_n[15:0] - 16'd2);
          end
        end else begin
          store_unstuffed(b);
        end
      end
      FR_ESCAPED: begin
        if (b == bsfd_pkg::MARK_START) begin
          open_frame_state();
          expect_result(bsfd_pkg::KIND_DROP, 8'h00, 16'h0000);
        end else if (b == bsfd_pkg::MARK_ESC || b == bsfd_pkg::MARK_END) begin
          fr_state = FR_HUNT;
          expect_result(bsfd_pkg::KIND_DROP, 8'h00, 16'h0000);
        end else begin
          store_unstuffed(b ^ bsfd_pkg::ESC_FLIP);
        end
      end
      default: fr_state = FR_HUNT;
    endcase
  endtask

  always @(posedge clk) begin
    bsfd_pkg::result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: kind %0d data_byte 0x%02h count %0d",
                 out_kind, out_data_byte, out_count);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_kind);
            errors++;
          end
          if (out_data_byte !== want.data_byte) begin
            $error("data_byte: expected 0x%02h, got 0x%02h", want.data_byte, out_data_byte);
            errors++;
          end
          if (out_count !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, out_count);
            errors++;
          end
          case (want.kind)
            bsfd_pkg::KIND_DATA: payload_seen++;
            bsfd_pkg::KIND_GOOD: good_seen++;
            bsfd_pkg::KIND_BAD:  bad_seen++;
            default:             drop_seen++;
          endcase
        end
      end
      if (in_valid && in_ready) begin
        decode_line_byte(in_rx_byte);
      end
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) begin
      rx_calm = !rx_calm;
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      if (!rx_calm && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send_line_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (!sender_calm && $urandom_range(0, 3) == 0) begin
      gap = pick_gap();
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic fill_body(input int len, input int mark_pct);
    repeat (len) body_buf.push_back(line_byte(mark_pct));
  endtask

  // Appends the frame check sequence to body_buf, optionally flips one bit, stuffs the lot and sends it as one frame.
  task automatic send_frame(input bit corrupt, input int esc_pct);
    logic [15:0] acc;
    logic [7:0]  b;
    int          pos;
    acc = bsfd_pkg::CRC_INIT;
    foreach (body_buf[i]) acc = x25_next(acc, body_buf[i]);
    acc = acc ^ bsfd_pkg::CRC_XOROUT;
    body_buf.push_back(acc[7:0]);
    body_buf.push_back(acc[15:8]);
    if (corrupt) begin
      pos = $urandom_range(0, body_buf.size() - 1);
      body_buf[pos] = body_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
    end
    send_line_byte(bsfd_pkg::MARK_START);
    foreach (body_buf[i]) begin
      b = body_buf[i];
      if (is_mark(b) || (!is_mark(b ^ bsfd_pkg::ESC_FLIP) && $urandom_range(0, 99) < esc_pct))
      begin
        send_line_byte(bsfd_pkg::MARK_ESC);
        send_line_byte(b ^ bsfd_pkg::ESC_FLIP);
      end else begin
        send_line_byte(b);
      end
    end
    send_line_byte(bsfd_pkg::MARK_END);
    body_buf.delete();
  endtask

  task automatic wait_decoder_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] value);
    cfg_psel   <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr  <= MAX_PAYLOAD_ADDR;
    cfg_pwdata <= {16'h0000, value};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    payload_limit = value;
    limit_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== value) begin
      $error("max_payload: expected %0d, got %0d", value, cfg_prdata[15:0]);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_framing_cases();
    logic [7:0] cases[$];
    cases = '{8'h42, bsfd_pkg::MARK_END, bsfd_pkg::MARK_ESC,
              bsfd_pkg::MARK_START, 8'h41, bsfd_pkg::MARK_END,
              bsfd_pkg::MARK_START, bsfd_pkg::MARK_START,
              bsfd_pkg::MARK_ESC, bsfd_pkg::MARK_START,
              bsfd_pkg::MARK_ESC, bsfd_pkg::MARK_ESC,
              bsfd_pkg::MARK_START, bsfd_pkg::MARK_ESC, bsfd_pkg::MARK_END,
              bsfd_pkg::MARK_START, 8'h00, 8'h00, bsfd_pkg::MARK_END};
    foreach (cases[i]) send_line_byte(cases[i]);
    body_buf.push_back(bsfd_pkg::MARK_START);
    body_buf.push_back(8'hFF);
    send_frame(1'b0, 0);
    wait_decoder_idle();
  endtask

  task automatic test_payload_limits();
    logic [15:0] limits[4];
    int          len;
    limits = '{16'd0, 16'd1, 16'd3, 16'hFFFF};
    foreach (limits[i]) begin
      write_max_payload(limits[i]);
      len = (limits[i] < 16'd8) ? int'(limits[i]) : 6;
      fill_body(len, 20);
      send_frame(1'b0, 0);
      fill_body(len + 1, 20);
      send_frame(1'b0, 10);
      fill_body(len, 20);
      send_frame(1'b1, 30);
      wait_decoder_idle();
    end
  endtask

  task automatic test_random_traffic();
    logic [15:0] settings[8];
    int unsigned target;
    int          len;
    int          pick;
    settings = '{16'd256, 16'd0, 16'd2, 16'hFFFF, 16'd1, 16'd12, 16'd5, 16'd256};
    settings[6] = 16'($urandom_range(4, 40));
    foreach (settings[s]) begin
      write_max_payload(settings[s]);
      target = decoded_bytes + RANDOM_ITEMS / 8;
      while (decoded_bytes < target) begin
        if ($urandom_range(0, 4) == 0) begin
          sender_calm = !sender_calm;
        end
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) send_line_byte(line_byte(10));
          end
          if (settings[s] <= 16'd8 && $urandom_range(0, 2) == 0) begin
            len = int'(settings[s]) + int'($urandom_range(0, 2));
          end else if ($urandom_range(0, 19) == 0) begin
            len = $urandom_range(30, 64);
          end else begin
            len = $urandom_range(0, 16);
          end
          fill_body(len, 15);
          send_frame($urandom_range(0, 5) == 0, $urandom_range(0, 1) ? 0 : 15);
        end else if (pick < 80) begin
          send_line_byte(bsfd_pkg::MARK_START);
          repeat ($urandom_range(0, 6)) send_line_byte(line_byte(5));
          case ($urandom_range(0, 2))
            0: ;
            1: begin
              send_line_byte(bsfd_pkg::MARK_ESC);
              send_line_byte($urandom_range(0, 1) ? bsfd_pkg::MARK_ESC : bsfd_pkg::MARK_END);
            end
            default: begin
              send_line_byte(bsfd_pkg::MARK_ESC);
              send_line_byte(bsfd_pkg::MARK_START);
            end
          endcase
        end else if (pick < 90) begin
          send_line_byte(bsfd_pkg::MARK_START);
          if ($urandom_range(0, 1)) begin
            send_line_byte(line_byte(0));
          end
          send_line_byte(bsfd_pkg::MARK_END);
        end else begin
          repeat ($urandom_range(1, 8)) send_line_byte(line_byte(25));
        end
      end
      wait_decoder_idle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_framing_cases();
    test_payload_limits();
    test_random_traffic();
    wait_decoder_idle();
    $display("Decoded %0d in-frame line bytes across %0d max_payload settings.",
             decoded_bytes, limit_writes);
    $display("Saw %0d payload bytes, %0d good, %0d bad-CRC and %0d dropped frames.",
             payload_seen, good_seen, bad_seen, drop_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bsfd_pkg.sv
hw/rtl/bsfd_cfg_regs.sv
hw/rtl/bsfd_in_reg.sv
hw/rtl/bsfd_core.sv
hw/rtl/byte_stuffed_frame_decoder_crc16_top.sv
hw/rtl/bsfd_checker.sv
tb/sv/byte_stuffed_frame_decoder_crc16_top_tb.sv
